// ===== design/dcmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dcmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 16;

   localparam int DIM_W   = 11;
   localparam int RAD_W   = 5;
   localparam int COL_W   = 10;
   localparam int PROW_W  = 11;
   localparam int IDX_W   = 21;
   localparam int DLY_W   = 15;
   localparam int SPAN_W  = RAD_W + 1;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
   localparam int SLOT_W    = $clog2(RING_ROWS);
   localparam int DIST_W    = SLOT_W + 1;
   localparam int LINE_LEN  = 2 * MAX_RADIUS + 1;
   localparam int VLEAVES   = RING_ROWS + 1;
   localparam int GRP       = 6;
   localparam int VGRPS     = (VLEAVES + GRP - 1) / GRP;
   localparam int HGRPS     = (LINE_LEN + GRP - 1) / GRP;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);
   localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(10);

   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_type;

   typedef struct packed {
      logic [7:0]       dark_value;
      logic [COL_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
      logic [IDX_W-1:0] total;
      logic [DLY_W-1:0] delay;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        pix;
      logic              wr;
      logic [COL_W-1:0]  pcol;
      logic [PROW_W-1:0] prow;
      logic [SLOT_W-1:0] slot;
      logic              oen;
      logic [COL_W-1:0]  orow;
      logic [COL_W-1:0]  ocol;
      logic              last;
   } step_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] raw,
                                               input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] v;
      v = raw;
      if (raw == '0) v = DIM_W'(1);
      else if (raw > lim) v = lim;
      return v;
   endfunction

   function automatic logic [RAD_W-1:0] sat_rad(input logic [RAD_W-1:0] raw);
      logic [RAD_W-1:0] v;
      v = raw;
      if ({1'b0, raw} > (RAD_W + 1)'(MAX_RADIUS)) v = RAD_W'(MAX_RADIUS);
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== design/dcmf_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dcmf_csr import dcmf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg,
   output logic                   restart
);
   logic [DIM_W-1:0] w_raw_ff, w_raw_in, h_raw_ff, h_raw_in;
   logic [RAD_W-1:0] r_raw_ff, r_raw_in;
   logic [DIM_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [RAD_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] total_ff, total_in;
   logic [DLY_W-1:0] delay_ff, delay_in;
   logic             wr_en;
   logic [1:0]       idx;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      w_raw_in = w_raw_ff;
      h_raw_in = h_raw_ff;
      r_raw_in = r_raw_ff;
      restart  = 1'b0;
      if (wr_en) begin
         unique case (idx)
            REG_FRAME_WIDTH: begin
               w_raw_in = pwdata[DIM_W-1:0];
               restart  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               h_raw_in = pwdata[DIM_W-1:0];
               restart  = 1'b1;
            end
            REG_WINDOW_RADIUS: begin
               r_raw_in = pwdata[RAD_W-1:0];
               restart  = 1'b1;
            end
            default: ;
         endcase
      end
      w_in     = sat_dim(w_raw_in, DIM_W'(MAX_WIDTH));
      h_in     = sat_dim(h_raw_in, DIM_W'(MAX_HEIGHT));
      r_in     = sat_rad(r_raw_in);
      total_in = IDX_W'(w_in * h_in);
      delay_in = DLY_W'(r_in * w_in) + DLY_W'(r_in);
   end

   always_comb begin
      unique case (idx)
         REG_FRAME_WIDTH:   prdata = DATA_W'(w_raw_ff);
         REG_FRAME_HEIGHT:  prdata = DATA_W'(h_raw_ff);
         REG_WINDOW_RADIUS: prdata = DATA_W'(r_raw_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_raw_ff <= RST_WIDTH;
         h_raw_ff <= RST_HEIGHT;
         r_raw_ff <= RST_RADIUS;
         w_ff     <= RST_WIDTH;
         h_ff     <= RST_HEIGHT;
         r_ff     <= RST_RADIUS;
         total_ff <= IDX_W'(RST_WIDTH * RST_HEIGHT);
         delay_ff <= DLY_W'(RST_RADIUS * RST_WIDTH) + DLY_W'(RST_RADIUS);
      end else begin
         w_raw_ff <= w_raw_in;
         h_raw_ff <= h_raw_in;
         r_raw_ff <= r_raw_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         r_ff     <= r_in;
         total_ff <= total_in;
         delay_ff <= delay_in;
      end
   end

   assign cfg.width  = w_ff;
   assign cfg.height = h_ff;
   assign cfg.radius = r_ff;
   assign cfg.total  = total_ff;
   assign cfg.delay  = delay_ff;

endmodule
`default_nettype wire

// ===== design/dcmf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dcmf_front import dcmf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    restart,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   input  wire req_type req_payload,
   output logic         req_stall,
   input  wire logic    q_full,
   output logic         push,
   output step_type     step
);
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_nx;
   logic [COL_W-1:0]  pcol_ff, pcol_in, ocol_ff, ocol_in;
   logic [PROW_W-1:0] prow_ff, prow_in;
   logic [COL_W-1:0]  orow_ff, orow_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              drain_ff, drain_in;
   logic              acc, oen, frame_end;
   logic [7:0]        mn;

   assign req_stall = q_full;

   always_comb begin
      acc  = req_valid && !q_full;
      push = acc && ((req_payload.action == ACT_DRAIN) == drain_ff);
      mn   = req_payload.blue;
      if (req_payload.green < mn) mn = req_payload.green;
      if (req_payload.red < mn) mn = req_payload.red;
      oen    = idx_ff >= IDX_W'(cfg.delay);
      idx_nx = idx_ff + IDX_W'(1);

      step.pix  = mn;
      step.wr   = !drain_ff;
      step.pcol = pcol_ff;
      step.prow = prow_ff;
      step.slot = slot_ff;
      step.oen  = oen;
      step.orow = orow_ff;
      step.ocol = ocol_ff;
      step.last = (DIM_W'(orow_ff) == cfg.height - DIM_W'(1)) &&
                  (DIM_W'(ocol_ff) == cfg.width - DIM_W'(1));

      idx_in    = idx_ff;
      pcol_in   = pcol_ff;
      prow_in   = prow_ff;
      slot_in   = slot_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      drain_in  = drain_ff;
      frame_end = 1'b0;

      if (push) begin
         idx_in = idx_nx;
         if (DIM_W'(pcol_ff) == cfg.width - DIM_W'(1)) begin
            pcol_in = '0;
            prow_in = prow_ff + PROW_W'(1);
            slot_in = (slot_ff == SLOT_W'(RING_ROWS - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end else begin
            pcol_in = pcol_ff + COL_W'(1);
         end
         if (oen) begin
            if (DIM_W'(ocol_ff) == cfg.width - DIM_W'(1)) begin
               ocol_in = '0;
               orow_in = orow_ff + COL_W'(1);
            end else begin
               ocol_in = ocol_ff + COL_W'(1);
            end
         end
         if (!drain_ff && idx_nx >= cfg.total) begin
            if (cfg.delay == '0) frame_end = 1'b1;
            else drain_in = 1'b1;
         end else if (drain_ff && idx_nx >= cfg.total + IDX_W'(cfg.delay)) begin
            frame_end = 1'b1;
         end
      end

      if (restart || frame_end) begin
         idx_in   = '0;
         pcol_in  = '0;
         prow_in  = '0;
         slot_in  = '0;
         ocol_in  = '0;
         orow_in  = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         pcol_ff  <= '0;
         prow_ff  <= '0;
         slot_ff  <= '0;
         ocol_ff  <= '0;
         orow_ff  <= '0;
         drain_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         pcol_ff  <= pcol_in;
         prow_ff  <= prow_in;
         slot_ff  <= slot_in;
         ocol_ff  <= ocol_in;
         orow_ff  <= orow_in;
         drain_ff <= drain_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dcmf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dcmf_queue import dcmf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire step_type push_data,
   input  wire logic     pop,
   output step_type      head,
   output logic          head_valid,
   output logic          full
);
   step_type            data_ff [QDEPTH];
   logic [QPTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign head       = data_ff[rp_ff];
   assign head_valid = cnt_ff != '0;
   assign full       = cnt_ff == (QPTR_W + 1)'(QDEPTH);

   always_comb begin
      wp_in  = push ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in  = pop ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dcmf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dcmf_back import dcmf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire step_type head,
   input  wire logic     head_valid,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);
   logic [7:0] line_mem_ff [RING_ROWS][MAX_WIDTH];
   logic [7:0] rd_ff [RING_ROWS];

   logic       adv;
   logic       a_v_ff, b_v_ff, c_v_ff, d_v_ff, rsp_valid_ff;
   step_type   a_ff, b_ff, c_ff, d_ff;
   logic [7:0] b_grp_ff [VGRPS];
   logic [7:0] b_grp_in [VGRPS];
   logic [7:0] c_vmin_ff, c_vmin_in;
   logic [7:0] hline_ff [LINE_LEN];
   logic [7:0] hline_in [LINE_LEN];
   logic [7:0] d_grp_ff [HGRPS];
   logic [7:0] d_grp_in [HGRPS];
   logic [7:0] vleaf [VLEAVES];
   logic [7:0] hleaf [LINE_LEN];
   logic [7:0] dark_in;
   rsp_type    rsp_ff;

   logic [DIST_W-1:0] dd;
   logic [SPAN_W-1:0] span;
   logic [DIM_W:0]    pos;

   assign adv         = !rsp_valid_ff || !rsp_stall;
   assign pop         = adv && head_valid;
   assign span        = {cfg.radius, 1'b0};
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // line buffers, one per ring row
   always_ff @(posedge clock) begin
      for (int g = 0; g < RING_ROWS; g++) begin
         if (pop && head.wr && head.slot == SLOT_W'(g))
            line_mem_ff[g][head.pcol] <= head.pix;
         if (adv) rd_ff[g] <= line_mem_ff[g][head.pcol];
      end
   end

   // vertical window: stored rows plus the pixel of this request
   always_comb begin
      for (int s = 0; s < RING_ROWS; s++) begin
         if (a_ff.slot >= SLOT_W'(s))
            dd = DIST_W'(a_ff.slot) - DIST_W'(s);
         else
            dd = DIST_W'(a_ff.slot) + DIST_W'(RING_ROWS) - DIST_W'(s);
         if (dd != '0 && PROW_W'(dd) <= PROW_W'(span) && PROW_W'(dd) <= a_ff.prow &&
             (a_ff.prow - PROW_W'(dd)) <= PROW_W'(cfg.height - DIM_W'(1)))
            vleaf[s] = rd_ff[s];
         else
            vleaf[s] = 8'hFF;
      end
      vleaf[RING_ROWS] = a_ff.wr ? a_ff.pix : 8'hFF;
      for (int g = 0; g < VGRPS; g++) b_grp_in[g] = 8'hFF;
      for (int n = 0; n < VLEAVES; n++) begin
         if (vleaf[n] < b_grp_in[n / GRP]) b_grp_in[n / GRP] = vleaf[n];
      end
   end

   always_comb begin
      c_vmin_in = 8'hFF;
      for (int g = 0; g < VGRPS; g++) begin
         if (b_grp_ff[g] < c_vmin_in) c_vmin_in = b_grp_ff[g];
      end
   end

   // horizontal window over the recent column minima
   always_comb begin
      hline_in[0] = c_vmin_ff;
      for (int i = 1; i < LINE_LEN; i++) hline_in[i] = hline_ff[i - 1];
      pos = (DIM_W + 1)'(c_ff.ocol) + (DIM_W + 1)'(cfg.radius);
      for (int i = 0; i < LINE_LEN; i++) begin
         if ((DIM_W + 1)'(i) <= (DIM_W + 1)'(span) && pos >= (DIM_W + 1)'(i) &&
             pos - (DIM_W + 1)'(i) <= (DIM_W + 1)'(cfg.width - DIM_W'(1)))
            hleaf[i] = hline_in[i];
         else
            hleaf[i] = 8'hFF;
      end
      for (int g = 0; g < HGRPS; g++) d_grp_in[g] = 8'hFF;
      for (int n = 0; n < LINE_LEN; n++) begin
         if (hleaf[n] < d_grp_in[n / GRP]) d_grp_in[n / GRP] = hleaf[n];
      end
   end

   always_comb begin
      dark_in = 8'hFF;
      for (int g = 0; g < HGRPS; g++) begin
         if (d_grp_ff[g] < dark_in) dark_in = d_grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= head;
         b_ff      <= a_ff;
         b_grp_ff  <= b_grp_in;
         c_ff      <= b_ff;
         c_vmin_ff <= c_vmin_in;
         d_ff      <= c_ff;
         d_grp_ff  <= d_grp_in;
         if (c_v_ff) hline_ff <= hline_in;
         if (d_v_ff && d_ff.oen) begin
            rsp_ff.dark_value <= dark_in;
            rsp_ff.pixel_row  <= d_ff.orow;
            rsp_ff.pixel_col  <= d_ff.ocol;
            rsp_ff.frame_last <= d_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff       <= head_valid;
         b_v_ff       <= a_v_ff;
         c_v_ff       <= b_v_ff;
         d_v_ff       <= c_v_ff;
         rsp_valid_ff <= d_v_ff && d_ff.oen;
      end
   end

endmodule
`default_nettype wire

// ===== design/dark_channel_min_filter.sv =====
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_type: action, blue, green, red
// rsp       out        rsp_valid/rsp_stall   rsp_type: dark_value, pixel_row, pixel_col,
//                                                      frame_last
// csr       in         psel/penable/pready   frame_width, frame_height, window_radius
//
// one request per clock sustained while req_stall is low, set by the single port of each line buffer
// a taken request passes through the queue, then stages a, b, c and d and the result register
// synchronous reset clears control state; line buffers need no clearing pass
// a four-entry queue between front and back absorbs rsp_stall while req keeps flowing
`timescale 1ns / 1ps
`default_nettype none
module dark_channel_min_filter import dcmf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);
   cfg_type  cfg;
   logic     restart, q_full, push, pop, head_valid;
   step_type step, head;

   dcmf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .restart (restart)
   );

   dcmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .step        (step)
   );

   dcmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (step),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   dcmf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head        (head),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== design/dcmf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dcmf_checker import dcmf_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rsp_type           rsp_payload,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [DATA_W-1:0] prdata,
   input wire logic              pready
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_prdata_narrow: assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite |-> prdata[DATA_W-1:DIM_W] == '0)
      else $error("register read has stray upper bits");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("register access not ready");

endmodule

bind dark_channel_min_filter dcmf_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import dcmf_pkg::*;

   localparam int RING = 2 * MAX_RADIUS + 2;
   localparam int CYCLE_LIMIT = 1000000;

   class dark_channel_scoreboard;
      rsp_type     expected_q[$];
      int          fails;
      bit [7:0]    line_mins[0:RING*MAX_WIDTH-1];
      int unsigned width_reg, height_reg, radius_reg;
      int unsigned taken, in_r, in_c, out_r, out_c;
      bit          drain_phase;

      function new();
         fails = 0;
         width_reg = 640;
         height_reg = 480;
         radius_reg = 10;
         restart();
      endfunction

      function void restart();
         taken = 0;
         in_r = 0;
         in_c = 0;
         out_r = 0;
         out_c = 0;
         drain_phase = 0;
      endfunction

      function int unsigned eff_w();
         if (width_reg == 0) return 1;
         return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      endfunction

      function int unsigned eff_h();
         if (height_reg == 0) return 1;
         return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      endfunction

      function int unsigned eff_r();
         return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      endfunction

      function void write_reg(logic [1:0] idx, int unsigned v);
         case (idx)
            REG_FRAME_WIDTH: width_reg = v & 'h7ff;
            REG_FRAME_HEIGHT: height_reg = v & 'h7ff;
            REG_WINDOW_RADIUS: radius_reg = v & 'h1f;
            default: return;
         endcase
         restart();
      endfunction

      function void note_request(req_type q);
         int unsigned w, h, r, total, dly, k, r0, r1, c0, c1, i, j;
         bit [7:0] m, best;
         rsp_type e;
         w = eff_w();
         h = eff_h();
         r = eff_r();
         total = w * h;
         dly = r * w + r;
         if (!drain_phase) begin
            if (q.action != ACT_PIXEL) return;
            m = q.blue;
            if (q.green < m) m = q.green;
            if (q.red < m) m = q.red;
            line_mins[(in_r % RING) * MAX_WIDTH + in_c] = m;
            in_c++;
            if (in_c >= w) begin
               in_c = 0;
               in_r++;
            end
         end else if (q.action != ACT_DRAIN) begin
            return;
         end
         k = taken;
         taken++;
         if (k >= dly) begin
            r0 = (out_r > r) ? out_r - r : 0;
            r1 = (out_r + r < h) ? out_r + r : h - 1;
            c0 = (out_c > r) ? out_c - r : 0;
            c1 = (out_c + r < w) ? out_c + r : w - 1;
            best = 8'hff;
            for (i = r0; i <= r1; i++)
               for (j = c0; j <= c1; j++)
                  if (line_mins[(i % RING) * MAX_WIDTH + j] < best)
                     best = line_mins[(i % RING) * MAX_WIDTH + j];
            e.dark_value = best;
            e.pixel_row = out_r[COL_W-1:0];
            e.pixel_col = out_c[COL_W-1:0];
            e.frame_last = (out_r == h - 1 && out_c == w - 1);
            expected_q.push_back(e);
            out_c++;
            if (out_c >= w) begin
               out_c = 0;
               out_r++;
            end
         end
         if (!drain_phase && taken >= total) begin
            if (dly == 0) restart();
            else drain_phase = 1;
         end else if (drain_phase && taken >= total + dly) begin
            restart();
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         fails++;
      endtask

      task check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         e = expected_q.pop_front();
         if (got.dark_value !== e.dark_value)
            report($sformatf("dark_value %0d exp %0d at %0d,%0d", got.dark_value,
                             e.dark_value, e.pixel_row, e.pixel_col));
         if (got.pixel_row !== e.pixel_row)
            report($sformatf("pixel_row %0d exp %0d", got.pixel_row, e.pixel_row));
         if (got.pixel_col !== e.pixel_col)
            report($sformatf("pixel_col %0d exp %0d", got.pixel_col, e.pixel_col));
         if (got.frame_last !== e.frame_last)
            report($sformatf("frame_last %0d exp %0d at %0d,%0d", got.frame_last,
                             e.frame_last, e.pixel_row, e.pixel_col));
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_payload;
   rsp_type rsp_payload;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   dark_channel_min_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   dark_channel_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycles = 0;
   int item_count = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   task send(req_type q);
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task csr_write(logic [1:0] idx, int unsigned v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx * 4);
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, v);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task set_frame(int unsigned w, int unsigned h, int unsigned r);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_WINDOW_RADIUS, r);
   endtask

   function req_type make_item(logic act);
      req_type q;
      q.action = act;
      q.blue = 8'($urandom);
      q.green = 8'($urandom);
      q.red = 8'($urandom);
      case ($urandom_range(7))
         0: q.green = 8'h00;
         1: begin
            q.blue = 8'hff;
            q.green = 8'hff;
            q.red = 8'hff;
         end
         2: q.red = 8'($urandom_range(3));
         default: ;
      endcase
      return q;
   endfunction

   // noise_pct: wrong-phase items mixed in; cut: index of the pixel after which the frame stops
   task run_frame(int noise_pct, int cut);
      int unsigned total, dly, p;
      total = sb.eff_w() * sb.eff_h();
      dly = sb.eff_r() * sb.eff_w() + sb.eff_r();
      for (p = 0; p < total; p++) begin
         if ($urandom_range(99) < noise_pct) send(make_item(ACT_DRAIN));
         send(make_item(ACT_PIXEL));
         item_count++;
         if (cut >= 0 && p == cut) return;
      end
      for (p = 0; p < dly; p++) begin
         if ($urandom_range(99) < noise_pct) send(make_item(ACT_PIXEL));
         send(make_item(ACT_DRAIN));
         item_count++;
      end
   endtask

   task random_phase();
      int unsigned w, h, r;
      int n;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      r = ($urandom_range(9) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 3);
      set_frame(w, h, r);
      if ($urandom_range(5) == 0) run_frame(10, $urandom_range(0, w * h - 1));
      else begin
         n = $urandom_range(1, 3);
         repeat (n) run_frame($urandom_range(3) == 0 ? 15 : 0, -1);
      end
   endtask

   initial begin
      req_type q;
      int mode, goal;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: min/max channels, wrong-phase items
      set_frame(3, 3, 1);
      q = '{action: ACT_DRAIN, blue: 8'h00, green: 8'h00, red: 8'h00};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'hff, green: 8'hff, red: 8'hff};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'h00, green: 8'hff, red: 8'hff};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'hff, green: 8'h00, red: 8'hff};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'hff, green: 8'hff, red: 8'h00};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'h80, green: 8'h7f, red: 8'hfe};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'h01, green: 8'h55, red: 8'haa};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'hff, green: 8'hff, red: 8'hff};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'h33, green: 8'h22, red: 8'h11};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'hfe, green: 8'hfd, red: 8'hfb};
      send(q);
      q = '{action: ACT_PIXEL, blue: 8'h00, green: 8'h00, red: 8'h00};
      send(q);
      repeat (4) send(make_item(ACT_DRAIN));
      set_frame(0, 0, 0);
      run_frame(0, -1);
      set_frame(3, 2, 31);
      run_frame(10, -1);
      set_frame(2047, 1, 0);
      run_frame(0, -1);
      set_frame(1, 2047, 0);
      run_frame(0, 40);
      set_frame(1, 1, 16);
      run_frame(20, -1);

      for (mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 22 : (mode == 1) ? 68 : 0;
         recv_idle = (mode == 0) ? 68 : (mode == 1) ? 22 : 0;
         if (mode == 2) begin
            set_frame(16, 8, 2);
            hold_ask = hold_ask + 1;
            run_frame(0, -1);
         end
         goal = item_count + 80;
         while (item_count < goal) random_phase();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
      if (sb.fails == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
